@@ rtl/dmt_pkg.sv @@
`default_nettype none
package dmt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int INTERLACE_BIT = 4;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = 5;
	localparam int TOL_W = 20;
	localparam int ADDR_W = 3;

	localparam logic REG_TOLERANCE = 1'b0;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_NEAR  = 2'd2,
		CMD_EXACT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] clock;
		logic [63:0] hor;
		logic [63:0] ver;
		logic [31:0] flags;
		logic [31:0] refresh;
		logic        dev;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start_clear;
		logic rd_more;
		logic pend;
		logic hit;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/dmt_regs.sv @@
`default_nettype none
module dmt_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dmt_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output logic      [dmt_pkg::TOL_W-1:0]     tolerance
);

	logic [dmt_pkg::TOL_W-1:0] tol_q;
	logic                      sel_tol;

	assign sel_tol = (paddr[2] == dmt_pkg::REG_TOLERANCE);
	assign pready = 1'b1;
	assign tolerance = tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= dmt_pkg::TOL_W'(100);
		end else if (psel && penable && pwrite && pready && sel_tol) begin
			tol_q <= pwdata[dmt_pkg::TOL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_tol) begin
			prdata = {{(32 - dmt_pkg::TOL_W){1'b0}}, tol_q};
		end
	end

endmodule
`default_nettype wire

@@ rtl/dmt_ctrl.sv @@
`default_nettype none
module dmt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire dmt_pkg::dp_stat_t  stat,
	output logic                    busy,
	output dmt_pkg::ctrl_cmd_t      ctl
);

	dmt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dmt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = stat.start_clear ? dmt_pkg::ST_FINISH : dmt_pkg::ST_SCAN;
				end
			end
			dmt_pkg::ST_SCAN: begin
				if (stat.hit || (!stat.rd_more && !stat.pend)) begin
					state_d = dmt_pkg::ST_FINISH;
				end
			end
			dmt_pkg::ST_FINISH: begin
				state_d = dmt_pkg::ST_IDLE;
			end
			default: begin
				state_d = dmt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b1;
		ctl = '0;
		case (state_q)
			dmt_pkg::ST_IDLE: begin
				busy = 1'b0;
				ctl.load = start;
			end
			dmt_pkg::ST_SCAN: begin
				ctl.rd_en = stat.rd_more && !stat.hit;
			end
			dmt_pkg::ST_FINISH: begin
				ctl.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/dmt_dpath.sv @@
`default_nettype none
module dmt_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dmt_pkg::ctrl_cmd_t            ctl,
	output dmt_pkg::dp_stat_t                  stat,
	input  wire logic [dmt_pkg::TOL_W-1:0]     tolerance,
	input  wire logic [1:0]                    cmd,
	input  wire logic [31:0]                   pixel_clock_khz,
	input  wire logic [63:0]                   horizontal_timing,
	input  wire logic [63:0]                   vertical_timing,
	input  wire logic [31:0]                   mode_flags,
	input  wire logic [31:0]                   refresh_millihertz,
	input  wire logic                          source_is_device,
	input  wire logic signed [1:0]             interlace_match,
	output logic                               done,
	output logic      [1:0]                    status,
	output logic      [dmt_pkg::SLOT_W-1:0]    slot_index,
	output logic      [31:0]                   found_clock_khz,
	output logic      [63:0]                   found_horizontal,
	output logic      [63:0]                   found_vertical,
	output logic      [31:0]                   found_flags,
	output logic      [31:0]                   found_refresh,
	output logic                               found_from_device
);

	dmt_pkg::entry_t                 mem_q [dmt_pkg::TABLE_ENTRIES];
	dmt_pkg::entry_t                 rdata_s1;
	dmt_pkg::entry_t                 key_q;
	dmt_pkg::cmd_t                   cmd_q;
	logic [1:0]                      imatch_q;
	logic [dmt_pkg::CNT_W-1:0]       count_q;
	logic [dmt_pkg::CNT_W-1:0]       rd_idx_q;
	logic [dmt_pkg::IDX_W-1:0]       idx_s1;
	logic                            valid_s1;
	logic                            hit_q;
	logic                            done_q;
	dmt_pkg::status_t                status_q;
	logic [dmt_pkg::SLOT_W-1:0]      slot_q;
	dmt_pkg::entry_t                 found_q;

	logic                            wh_eq;
	logic [31:0]                     rdiff;
	logic                            near_ok;
	logic                            il_any;
	logic                            il_want;
	logic                            il_ok;
	logic                            match;
	logic                            room;
	logic                            wr_en;
	logic [dmt_pkg::IDX_W-1:0]       wr_addr;

	assign wh_eq = (rdata_s1.hor[15:0] == key_q.hor[15:0]) &&
		(rdata_s1.ver[15:0] == key_q.ver[15:0]);
	assign rdiff = (rdata_s1.refresh > key_q.refresh) ?
		rdata_s1.refresh - key_q.refresh : key_q.refresh - rdata_s1.refresh;
	assign near_ok = (rdiff <= {{(32 - dmt_pkg::TOL_W){1'b0}}, tolerance});
	assign il_any = (cmd_q == dmt_pkg::CMD_ADD) ? 1'b0 : imatch_q[1];
	assign il_want = (cmd_q == dmt_pkg::CMD_ADD) ?
		key_q.flags[dmt_pkg::INTERLACE_BIT] : imatch_q[0];
	assign il_ok = il_any || (rdata_s1.flags[dmt_pkg::INTERLACE_BIT] == il_want);

	always_comb begin
		if (cmd_q == dmt_pkg::CMD_EXACT) begin
			match = (rdata_s1.clock == key_q.clock) &&
				(rdata_s1.hor[63:48] == key_q.hor[63:48]) &&
				(rdata_s1.ver[63:48] == key_q.ver[63:48]) && wh_eq && il_ok;
		end else begin
			match = wh_eq && near_ok && il_ok;
		end
	end

	assign stat.start_clear = (cmd == dmt_pkg::CMD_CLEAR);
	assign stat.rd_more = (rd_idx_q < count_q);
	assign stat.pend = valid_s1;
	assign stat.hit = valid_s1 && match;

	assign room = (count_q < dmt_pkg::CNT_W'(dmt_pkg::TABLE_ENTRIES));
	assign wr_en = ctl.finish && (cmd_q == dmt_pkg::CMD_ADD) && (hit_q || room);
	assign wr_addr = hit_q ? idx_s1 : count_q[dmt_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			hit_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.finish;
			valid_s1 <= ctl.rd_en;
			if (ctl.load) begin
				rd_idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (ctl.rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (stat.hit) begin
					hit_q <= 1'b1;
				end
			end
			if (ctl.finish && (cmd_q == dmt_pkg::CMD_CLEAR)) begin
				count_q <= '0;
			end else if (wr_en && !hit_q) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= dmt_pkg::cmd_t'(cmd);
			imatch_q <= interlace_match;
			key_q.clock <= pixel_clock_khz;
			key_q.hor <= horizontal_timing;
			key_q.ver <= vertical_timing;
			key_q.flags <= mode_flags;
			key_q.refresh <= refresh_millihertz;
			key_q.dev <= source_is_device;
		end
		if (ctl.rd_en) begin
			rdata_s1 <= mem_q[rd_idx_q[dmt_pkg::IDX_W-1:0]];
			idx_s1 <= rd_idx_q[dmt_pkg::IDX_W-1:0];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status_q <= dmt_pkg::STAT_OK;
			slot_q <= '0;
			found_q <= '0;
			case (cmd_q)
				dmt_pkg::CMD_CLEAR: begin
					status_q <= dmt_pkg::STAT_OK;
				end
				dmt_pkg::CMD_ADD: begin
					if (hit_q || room) begin
						slot_q <= dmt_pkg::SLOT_W'(wr_addr);
					end else begin
						status_q <= dmt_pkg::STAT_FULL;
					end
				end
				default: begin
					if (hit_q) begin
						slot_q <= dmt_pkg::SLOT_W'(idx_s1);
						found_q <= rdata_s1;
					end else begin
						status_q <= dmt_pkg::STAT_MISS;
					end
				end
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign slot_index = slot_q;
	assign found_clock_khz = found_q.clock;
	assign found_horizontal = found_q.hor;
	assign found_vertical = found_q.ver;
	assign found_flags = found_q.flags;
	assign found_refresh = found_q.refresh;
	assign found_from_device = found_q.dev;

endmodule
`default_nettype wire

@@ rtl/display_mode_table_unit.sv @@
// Channel   Handshake              Payload
// command   start / busy           cmd, pixel_clock_khz, horizontal_timing, vertical_timing,
//                                  mode_flags, refresh_millihertz, source_is_device,
//                                  interlace_match
// result    done (1-cycle strobe)  status, slot_index, found_*
// config    APB psel/penable/pwrite, paddr[2:0], pwdata, prdata, pready
//
// Clear goes from start straight to the finish state. Other commands first scan the n stored
// entries and then finish, stopping the scan early when a match is found:
// one entry is read from the table memory per cycle and compared the next cycle.
// arst_n clears the entry count, so the table comes out of reset empty.
// done is high for one cycle and cannot be held off; start is taken only while busy is low.
`default_nettype none
module display_mode_table_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dmt_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    cmd,
	input  wire logic [31:0]                   pixel_clock_khz,
	input  wire logic [63:0]                   horizontal_timing,
	input  wire logic [63:0]                   vertical_timing,
	input  wire logic [31:0]                   mode_flags,
	input  wire logic [31:0]                   refresh_millihertz,
	input  wire logic                          source_is_device,
	input  wire logic signed [1:0]             interlace_match,
	output logic                               done,
	output logic      [1:0]                    status,
	output logic      [4:0]                    slot_index,
	output logic      [31:0]                   found_clock_khz,
	output logic      [63:0]                   found_horizontal,
	output logic      [63:0]                   found_vertical,
	output logic      [31:0]                   found_flags,
	output logic      [31:0]                   found_refresh,
	output logic                               found_from_device
);

	logic [dmt_pkg::TOL_W-1:0] tolerance;
	dmt_pkg::ctrl_cmd_t        ctl;
	dmt_pkg::dp_stat_t         stat;

	dmt_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tolerance (tolerance)
	);

	dmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	dmt_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (ctl),
		.stat               (stat),
		.tolerance          (tolerance),
		.cmd                (cmd),
		.pixel_clock_khz    (pixel_clock_khz),
		.horizontal_timing  (horizontal_timing),
		.vertical_timing    (vertical_timing),
		.mode_flags         (mode_flags),
		.refresh_millihertz (refresh_millihertz),
		.source_is_device   (source_is_device),
		.interlace_match    (interlace_match),
		.done               (done),
		.status             (status),
		.slot_index         (slot_index),
		.found_clock_khz    (found_clock_khz),
		.found_horizontal   (found_horizontal),
		.found_vertical     (found_vertical),
		.found_flags        (found_flags),
		.found_refresh      (found_refresh),
		.found_from_device  (found_from_device)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("transaction ended without a result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != dmt_pkg::STAT_OK)) |-> (slot_index == '0 && found_clock_khz == '0))
		else $error("failed transaction returned nonzero fields");

endmodule
`default_nettype wire
